// File: src/btpc_pkg.sv
// Package: shared types and constants for the barometric compensation block.
package btpc_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNoTemp = 2'd1;
  localparam logic [1:0] StatusZeroDiv = 2'd2;

  localparam logic [1:0] RegCalibA = 2'd0;
  localparam logic [1:0] RegCalibB = 2'd1;
  localparam logic [1:0] RegCalibC = 2'd2;
  localparam logic [1:0] RegOss    = 2'd3;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OpNone,
    OpTLoad,    // a = raw - ac6
    OpTMul,     // x1 = (a*ac5) >>> 15
    OpTDen,     // den = x1 + md, num = mc << 11
    OpDivStart,
    OpTFinish,  // b5 = x1 + q, result
    OpPB6,      // b6 = b5 - 4000
    OpPB6Sq,    // b6sq = (b6*b6) >>> 12
    OpPX1,      // t1 = (b2*b6sq) >>> 11
    OpPX2,      // t2 = (ac2*b6) >>> 11
    OpPB3,      // b3
    OpPX1b,     // t1 = (ac3*b6) >>> 13
    OpPX2b,     // t2 = (b1*b6sq) >>> 16
    OpPX3,      // x3 = (t1+t2+2) >>> 2
    OpPB4,      // b4 = (ac4*(x3+32768)) >> 15; divisor setup
    OpPB7,      // b7 = (raw-b3)*(50000>>oss), numerator setup
    OpPQuot,    // p from quotient
    OpPSq,      // t1 = (p>>>8)*(p>>>8)
    OpPX1c,     // t1 = (t1*3038) >>> 16
    OpPX2c,     // t2 = (-7357*p) >>> 16
    OpPFinal    // p += (t1+t2+3791) >>> 4
  } op_t;

  typedef struct packed {
    logic den_zero;
    logic b4_zero;
    logic div_busy;
  } dp_status_t;

endpackage

// File: src/baro_temp_pressure_compensation.sv
// Top level: barometric temperature and pressure compensation.
// Input channel: in_valid/in_stall with func and raw_sample. func 0 carries a
// raw temperature word, func 1 a raw pressure word aligned to 19 bits.
// Output channel: out_valid/out_stall with result_kind, compensated_value
// (0.1 C or Pa) and status_code; one result word per input word.
// Calibration and oversampling are loaded through cfg_we/cfg_index/cfg_data
// while the block is idle; the user must keep to this, the block itself
// does not enforce it. One word is worked at a time. Both word kinds are
// timed by the serial divider plus the steps around the single shared
// 32x32 multiplier. Error words return sooner: for no temperature yet, for a
// temperature zero divisor and for a pressure zero divisor.
// Reset clears calibration, the kept B5 and the temperature-seen flag.
// A stalled result holds its output register; the next word is not taken
// until that register frees up.
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [18:0] raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] compensated_value,
  output logic [1:0]  status_code
);

  logic [63:0] calib_a, calib_b;
  logic [31:0] calib_c;
  logic [1:0]  oss;
  logic [18:0] raw;
  op_t         op;
  dp_status_t  dstat;
  logic        b5_we;
  logic [31:0] t_value, p_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_a <= 64'd0;
      calib_b <= 64'd0;
      calib_c <= 32'd0;
      oss     <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCalibA: calib_a <= cfg_data;
        RegCalibB: calib_b <= cfg_data;
        RegCalibC: calib_c <= cfg_data[31:0];
        RegOss:    oss <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  btpc_datapath u_dp (
    .clk, .rst, .op,
    .calib_group_a(calib_a), .calib_group_b(calib_b), .calib_group_c(calib_c),
    .oversampling(oss), .raw, .b5_we, .t_value, .p_value,
    .status(dstat)
  );

  btpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .func, .raw_sample, .raw, .op,
    .status(dstat), .t_value, .p_value, .b5_we, .out_valid, .out_stall,
    .result_kind, .compensated_value, .status_code
  );

endmodule

// File: src/btpc_datapath.sv
// Datapath: shared multiplier, serial divider and working registers.
module btpc_datapath
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic [63:0] calib_group_a,
  input  logic [63:0] calib_group_b,
  input  logic [31:0] calib_group_c,
  input  logic [1:0]  oversampling,
  input  logic [18:0] raw,
  input  logic        b5_we,
  output logic [31:0] t_value,
  output logic [31:0] p_value,
  output dp_status_t  status
);

  logic [31:0] a, x1, t1, t2, b6, b6sq, b3, b4, kept;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] raw32;
  logic [31:0] b5_val;
  // divider
  logic [31:0] dvd, dvs, quo, rem;
  logic [5:0]  cnt;
  logic        neg_q, busy, sgn_mode;
  logic [32:0] trial;

  assign raw32 = {13'd0, raw};
  assign ac1 = {{16{calib_group_a[63]}}, calib_group_a[63:48]};
  assign ac2 = {{16{calib_group_a[47]}}, calib_group_a[47:32]};
  assign ac3 = {{16{calib_group_a[31]}}, calib_group_a[31:16]};
  assign ac4 = {16'd0, calib_group_a[15:0]};
  assign ac5 = {16'd0, calib_group_b[63:48]};
  assign ac6 = {16'd0, calib_group_b[47:32]};
  assign b1  = {{16{calib_group_b[31]}}, calib_group_b[31:16]};
  assign b2  = {{16{calib_group_b[15]}}, calib_group_b[15:0]};
  assign mc  = {{16{calib_group_c[31]}}, calib_group_c[31:16]};
  assign md  = {{16{calib_group_c[15]}}, calib_group_c[15:0]};

  always_comb begin
    mul_a = a;
    mul_b = ac5;
    case (op)
      OpPB6Sq: begin mul_a = b6; mul_b = b6; end
      OpPX1:   begin mul_a = b2; mul_b = b6sq; end
      OpPX2:   begin mul_a = ac2; mul_b = b6; end
      OpPX1b:  begin mul_a = ac3; mul_b = b6; end
      OpPX2b:  begin mul_a = b1; mul_b = b6sq; end
      OpPB4:   begin mul_a = ac4; mul_b = t1 + 32'd32768; end
      OpPB7:   begin mul_a = raw32 - b3; mul_b = 32'd50000 >> oversampling; end
      OpPSq:   begin
        mul_a = 32'($signed(a) >>> 8);
        mul_b = 32'($signed(a) >>> 8);
      end
      OpPX1c:  begin mul_a = t1; mul_b = 32'd3038; end
      OpPX2c:  begin mul_a = 32'hFFFFE343; mul_b = a; end
      default: begin mul_a = a; mul_b = ac5; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign trial = {rem[31:0], dvd[31]} - {1'b0, dvs};

  assign b5_val  = x1 + quo;
  assign t_value = 32'($signed(b5_val + 32'd8) >>> 4);
  assign p_value = a;
  assign status.den_zero = (dvs == 32'd0);
  assign status.b4_zero  = (b4 == 32'd0);
  assign status.div_busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kept <= 32'd0;
      cnt  <= 6'd0;
    end else begin
      if (b5_we) kept <= b5_val;
      case (op)
        OpTLoad: a <= raw32 - ac6;
        OpTMul:  x1 <= 32'($signed(prod) >>> 15);
        OpTDen: begin
          // signed divide: work on magnitudes
          dvd <= mc[31] ? -(mc << 11) : (mc << 11);
          dvs <= ((x1 + md) & 32'h8000_0000) != 0 ? -(x1 + md) : (x1 + md);
          neg_q <= mc[31] ^ ((x1 + md) >> 31 != 0);
          sgn_mode <= 1'b1;
        end
        OpDivStart: begin
          busy <= 1'b1;
          cnt  <= 6'(DivSteps);
          rem  <= 32'd0;
          quo  <= 32'd0;
        end
        OpPB6: b6 <= kept - 32'd4000;
        OpPB6Sq: b6sq <= 32'($signed(prod) >>> 12);
        OpPX1: t1 <= 32'($signed(prod) >>> 11);
        OpPX2: t2 <= 32'($signed(prod) >>> 11);
        OpPB3: b3 <= 32'($signed((((ac1 << 2) + t1 + t2) << oversampling) + 32'd2) >>> 2);
        OpPX1b: t1 <= 32'($signed(prod) >>> 13);
        OpPX2b: t2 <= 32'($signed(prod) >>> 16);
        OpPX3: t1 <= 32'($signed(t1 + t2 + 32'd2) >>> 2);
        OpPB4: begin
          b4  <= prod >> 15;
          dvs <= prod >> 15;
          sgn_mode <= 1'b0;
          neg_q <= 1'b0;
        end
        OpPB7: begin
          // b7 < 2^31: divide 2*b7; else divide b7 and double afterward
          a   <= prod;
          dvd <= prod[31] ? prod : (prod << 1);
        end
        OpPQuot: a <= a[31] ? (quo << 1) : quo;
        OpPX1c: t1 <= 32'($signed(prod) >>> 16);
        OpPX2c: t2 <= 32'($signed(prod) >>> 16);
        OpPSq: t1 <= prod;
        OpPFinal: a <= a + 32'($signed(t1 + t2 + 32'd3791) >>> 4);
        default: ;
      endcase
      if (busy) begin
        // restoring divide, one quotient bit a cycle
        dvd <= dvd << 1;
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], dvd[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) busy <= 1'b0;
      end else if (op == OpTFinish && sgn_mode && neg_q) begin
        quo <= -quo;
      end
    end
  end

endmodule

// File: src/btpc_ctrl.sv
// Controller: sequences the datapath for one word at a time.
module btpc_ctrl
  import btpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [18:0] raw_sample,
  output logic [18:0] raw,
  output op_t         op,
  input  dp_status_t  status,
  input  logic [31:0] t_value,
  input  logic [31:0] p_value,
  output logic        b5_we,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] compensated_value,
  output logic [1:0]  status_code
);

  typedef enum logic [4:0] {
    Idle, TLoad, TMul, TDen, TDiv, TWait, TSign, TDone,
    PB6, PSq, PX1, PX2, PB3, PX1b, PX2b, PX3, PB4, PB7, PDiv, PWait,
    PQuot, PPsq, PX1c, PX2c, PFin, PDone, Emit
  } state_t;

  state_t state;
  logic   have_t;

  assign in_stall = (state != Idle) || (out_valid && out_stall);

  always_comb begin
    op = OpNone;
    b5_we = 1'b0;
    case (state)
      TLoad: op = OpTLoad;
      TMul:  op = OpTMul;
      TDen:  op = OpTDen;
      TDiv:  op = OpDivStart;
      PDiv:  op = OpDivStart;
      TSign: op = OpTFinish;
      TDone: b5_we = 1'b1;
      PB6:   op = OpPB6;
      PSq:   op = OpPB6Sq;
      PX1:   op = OpPX1;
      PX2:   op = OpPX2;
      PB3:   op = OpPB3;
      PX1b:  op = OpPX1b;
      PX2b:  op = OpPX2b;
      PX3:   op = OpPX3;
      PB4:   op = OpPB4;
      PB7:   op = OpPB7;
      PQuot: op = OpPQuot;
      PPsq:  op = OpPSq;
      PX1c:  op = OpPX1c;
      PX2c:  op = OpPX2c;
      PFin:  op = OpPFinal;
      default: op = OpNone;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      have_t <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        Idle: if (in_valid && !in_stall) begin
          raw <= raw_sample;
          result_kind <= func;
          if (!func) state <= TLoad;
          else if (!have_t) begin
            compensated_value <= 32'd0;
            status_code <= StatusNoTemp;
            state <= Emit;
          end else state <= PB6;
        end
        TLoad: state <= TMul;
        TMul:  state <= TDen;
        TDen:  state <= TWait;
        TWait: if (status.den_zero) begin
          compensated_value <= 32'd0;
          status_code <= StatusZeroDiv;
          state <= Emit;
        end else state <= TDiv;
        TDiv:  state <= TSign;
        TSign: if (!status.div_busy) state <= TDone;
        TDone: begin
          have_t <= 1'b1;
          compensated_value <= t_value;
          status_code <= StatusOk;
          state <= Emit;
        end
        PB6: state <= PSq;
        PSq: state <= PX1;
        PX1: state <= PX2;
        PX2: state <= PB3;
        PB3: state <= PX1b;
        PX1b: state <= PX2b;
        PX2b: state <= PX3;
        PX3: state <= PB4;
        PB4: state <= PB7;
        PB7: if (status.b4_zero) begin
          compensated_value <= 32'd0;
          status_code <= StatusZeroDiv;
          state <= Emit;
        end else state <= PDiv;
        PDiv: state <= PWait;
        PWait: if (!status.div_busy) state <= PQuot;
        PQuot: state <= PPsq;
        PPsq: state <= PX1c;
        PX1c: state <= PX2c;
        PX2c: state <= PFin;
        PFin: state <= PDone;
        PDone: begin
          compensated_value <= p_value;
          status_code <= StatusOk;
          state <= Emit;
        end
        Emit: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          state <= Idle;
        end
        default: state <= Idle;
      endcase
    end
  end

endmodule
